// ===== hdl/smoothstep_fixed_point_macros.svh =====
// Assertion macros shared by the smoothstep checker.
`ifndef SMOOTHSTEP_FIXED_POINT_MACROS_SVH
`define SMOOTHSTEP_FIXED_POINT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define SSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define SSFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/ssfp_pkg.sv =====
// Package with the default formats of the smoothstep pipeline.
`timescale 1ns / 1ps

package ssfp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_BITS_DEF = 32;

endpackage

// ===== hdl/smoothstep_fixed_point.sv =====
// Pipelined fixed-point smoothstep: clamp((x-lo)/(hi-lo)) then t*t*(3-2t).
//
//   channel | dir | tdata (low bit up)                     | tlast
//   --------+-----+----------------------------------------+---------------
//   in_     | in  | edge_low, edge_high, sample (DATA_BITS) | batch_end
//   out_    | out | smooth_value (FRAC_BITS+1, Q1.FRAC)     | batch_end_out
//
// One beat per cycle sustained while the skid entry is empty; a result passes
// three setup stages, one restoring-division stage per quotient bit, two
// multiplier stages and the output register.
// A two-entry output (register plus skid) lets the pipeline keep accepting
// while one result waits; in_tready drops only when both entries are full.
// Reset clears the valid bits of all stages and of the output entries.
`timescale 1ns / 1ps

module smoothstep_fixed_point #(
  parameter int FRAC_BITS = ssfp_pkg::FRAC_BITS_DEF,
  parameter int DATA_BITS = ssfp_pkg::DATA_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // edge_low [D-1:0], edge_high [2D-1:D], sample [3D-1:2D], zero pad
  input  logic [((3*DATA_BITS+7)/8)*8-1:0]       in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // smooth_value [FRAC_BITS:0], zero pad
  output logic [((FRAC_BITS+8)/8)*8-1:0]         out_tdata,
  output logic                                   out_tlast
);

  import ssfp_pkg::*;

  localparam int D     = DATA_BITS;
  localparam int F     = FRAC_BITS;
  localparam int OUT_W = ((F + 8) / 8) * 8;
  localparam int NST   = F + 5;
  localparam logic [F:0]   ONE_Q   = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] THREE_Q = {2'b11, {F{1'b0}}};

  logic           adv;
  logic [NST-1:0] vld_r;

  // stage 0: span and numerator, exact in D+1 bits
  logic [D:0] lo_e, hi_e, x_e;
  logic [D:0] s0_span_r, s0_num_r;
  logic       s0_last_r;

  // stage 1: zero-span fix and sign normalization
  logic [D:0]   span_z, span_n, num_n;
  logic [D-1:0] s1_span_r;
  logic [D:0]   s1_num_r;
  logic         s1_last_r;

  // stage 2 (entry 0) and division stages (entries 1..F)
  logic [D-1:0] dv_rem_r  [F+1];
  logic [D-1:0] dv_span_r [F+1];
  logic [F-1:0] dv_q_r    [F+1];
  logic         dv_lo_r   [F+1];
  logic         dv_hi_r   [F+1];
  logic         dv_last_r [F+1];

  // multiplier stages
  logic [F:0]       t_sel;
  logic [2*F+1:0]   prod1;
  logic [F+1:0]     w_val;
  logic [F:0]       m1_sq_r;
  logic [F+1:0]     m1_w_r;
  logic             m1_last_r;
  logic [2*F+2:0]   prod2;
  logic [F:0]       m2_res_r;
  logic             m2_last_r;

  // output register and skid entry
  logic       o_vld_r, skid_vld_r, o_last_r, skid_last_r;
  logic [F:0] o_data_r, skid_data_r;
  logic       o_free, p_vld;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  assign lo_e = {in_tdata[D-1], in_tdata[D-1:0]};
  assign hi_e = {in_tdata[2*D-1], in_tdata[2*D-1:D]};
  assign x_e  = {in_tdata[3*D-1], in_tdata[3*D-1:2*D]};

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_span_r <= hi_e - lo_e;
      s0_num_r  <= x_e - lo_e;
      s0_last_r <= in_tlast;
    end
  end

  always_comb begin
    span_z = (s0_span_r == '0) ? (D+1)'(1) : s0_span_r;
    span_n = span_z[D] ? -span_z : span_z;
    num_n  = span_z[D] ? -s0_num_r : s0_num_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_span_r <= span_n[D-1:0];
      s1_num_r  <= num_n;
      s1_last_r <= s0_last_r;
    end
  end

  // clamp decisions; the remainder seeds the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_lo_r[0]   <= s1_num_r[D] || (s1_num_r == '0);
      dv_hi_r[0]   <= !s1_num_r[D] && (s1_num_r[D-1:0] >= s1_span_r);
      dv_rem_r[0]  <= s1_num_r[D-1:0];
      dv_span_r[0] <= s1_span_r;
      dv_q_r[0]    <= '0;
      dv_last_r[0] <= s1_last_r;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [D:0] rem2, diff;
    logic       take;

    assign rem2 = {dv_rem_r[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dv_span_r[k-1]};
    assign take = rem2 >= {1'b0, dv_span_r[k-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k]  <= take ? diff[D-1:0] : rem2[D-1:0];
        dv_q_r[k]    <= {dv_q_r[k-1][F-2:0], take};
        dv_span_r[k] <= dv_span_r[k-1];
        dv_lo_r[k]   <= dv_lo_r[k-1];
        dv_hi_r[k]   <= dv_hi_r[k-1];
        dv_last_r[k] <= dv_last_r[k-1];
      end
    end
  end

  always_comb begin
    if (dv_lo_r[F]) begin
      t_sel = '0;
    end else if (dv_hi_r[F]) begin
      t_sel = ONE_Q;
    end else begin
      t_sel = {1'b0, dv_q_r[F]};
    end
    prod1 = (2*F+2)'(t_sel) * (2*F+2)'(t_sel);
    w_val = THREE_Q - {t_sel, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sq_r   <= prod1[2*F:F];
      m1_w_r    <= w_val;
      m1_last_r <= dv_last_r[F];
    end
  end

  assign prod2 = (2*F+3)'(m1_sq_r) * (2*F+3)'(m1_w_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_res_r  <= prod2[2*F:F];
      m2_last_r <= m1_last_r;
    end
  end

  assign o_free = !o_vld_r || out_tready;
  assign p_vld  = vld_r[NST-1] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r    <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (o_free) begin
        o_vld_r    <= skid_vld_r || p_vld;
        skid_vld_r <= 1'b0;
      end else if (p_vld) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  // drain the skid entry first; park a new beat there while the output stalls
  always_ff @(posedge clk) begin
    if (o_free) begin
      o_data_r <= skid_vld_r ? skid_data_r : m2_res_r;
      o_last_r <= skid_vld_r ? skid_last_r : m2_last_r;
    end
    if (!o_free && p_vld) begin
      skid_data_r <= m2_res_r;
      skid_last_r <= m2_last_r;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = OUT_W'(o_data_r);
  assign out_tlast  = o_last_r;

endmodule

// ===== hdl/ssfp_checker.sv =====
// Port-level checker for the smoothstep pipeline, bound to the top level.
`timescale 1ns / 1ps
`include "smoothstep_fixed_point_macros.svh"

module ssfp_checker #(
  parameter int FRAC_BITS = ssfp_pkg::FRAC_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [((FRAC_BITS+8)/8)*8-1:0]  out_tdata,
  input logic                            out_tlast
);

  import ssfp_pkg::*;

  localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;
  localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;

  // a stalled result beat holds
  `SSFP_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast),
    "result beat changed under stall")

  // the input side backs up only behind a waiting result
  `SSFP_ASSERT(a_ready_cause, !in_tready |-> out_tvalid, "input stalled with no result waiting")

  // result never exceeds one and the pad bits stay clear
  `SSFP_ASSERT(a_out_range, out_tvalid |-> out_tdata <= ONE_Q, "smooth value above one")

  // reset empties the output
  `SSFP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result beat right after reset")

endmodule

bind smoothstep_fixed_point ssfp_checker #(.FRAC_BITS(FRAC_BITS)) u_ssfp_checker (.*);
